@@ rtl/sdcd_pkg.sv @@
// Shared types and constants for the stereo decimate / cross delay core.
// No dependencies; every other file imports this package.
package sdcd_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int QUARTER_W        = SAMPLE_W - 2;
    localparam int DELAY_CFG_W      = 13;
    localparam int MAX_DELAY_FRAMES = 4096;
    localparam int QUEUE_DEPTH      = 2;
    localparam int MIN_DELAY_FRAMES = 2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] first_left;
        logic signed [SAMPLE_W-1:0] first_right;
        logic signed [SAMPLE_W-1:0] second_left;
        logic signed [SAMPLE_W-1:0] second_right;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
    } out_item_t;

endpackage

@@ rtl/sdcd_fifo.sv @@
// Small two-entry register queue used between the core's stages.
// Depends on sdcd_pkg for the queue depth.
module sdcd_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    import sdcd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/sdcd_front.sv @@
// Front end: accepts input beats, runs the 2:1 decimator, holds the delay
// length register and assigns each beat its ring slot. Depends on sdcd_pkg.
module sdcd_front #(
    parameter int MAX_DELAY_FRAMES = sdcd_pkg::MAX_DELAY_FRAMES,
    parameter int IDX_W            = $clog2(MAX_DELAY_FRAMES)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  sdcd_pkg::in_item_t                  in_item,
    input  logic                                cfg_valid,
    input  logic [sdcd_pkg::DELAY_CFG_W-1:0]    cfg_data,
    input  logic                                clearing,
    input  logic                                mid_full,
    output logic                                mid_push,
    output logic                                mid_mix,
    output logic [IDX_W-1:0]                    mid_idx,
    output sdcd_pkg::out_item_t                 mid_pair
);
    import sdcd_pkg::*;

    localparam int MAXC_W = $clog2(MAX_DELAY_FRAMES + 1);
    localparam int LEN_W  = (DELAY_CFG_W > MAXC_W) ? DELAY_CFG_W : MAXC_W;

    logic [DELAY_CFG_W-1:0]     delay_frames_reg;
    logic signed [QUARTER_W-1:0] held_left_reg, held_left_next;
    logic signed [QUARTER_W-1:0] held_right_reg, held_right_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [LEN_W-1:0]           len_cfg;
    logic [LEN_W-1:0]           len_eff;
    logic [LEN_W-1:0]           idx_inc;
    logic                       accept;

    assign full   = mid_full || clearing;
    assign accept = push && !full;

    // effective ring length: clamp to the store size
    assign len_cfg = LEN_W'(delay_frames_reg);
    assign len_eff = (len_cfg > LEN_W'(MAX_DELAY_FRAMES)) ? LEN_W'(MAX_DELAY_FRAMES) : len_cfg;
    assign idx_inc = LEN_W'(idx_reg) + 1'b1;

    assign held_left_next  = in_item.second_left[SAMPLE_W-1:2];
    assign held_right_next = in_item.second_right[SAMPLE_W-1:2];

    always_comb
    begin
        mid_push = accept;
        mid_mix  = (len_cfg >= LEN_W'(MIN_DELAY_FRAMES));
        mid_idx  = idx_reg;
        mid_pair.out_left  = {{2{held_left_reg[QUARTER_W-1]}}, held_left_reg}
                           + {in_item.first_left[SAMPLE_W-1], in_item.first_left[SAMPLE_W-1:1]}
                           + {{2{held_left_next[QUARTER_W-1]}}, held_left_next};
        mid_pair.out_right = {{2{held_right_reg[QUARTER_W-1]}}, held_right_reg}
                           + {in_item.first_right[SAMPLE_W-1], in_item.first_right[SAMPLE_W-1:1]}
                           + {{2{held_right_next[QUARTER_W-1]}}, held_right_next};
        idx_next = idx_reg;
        if (accept && mid_mix)
        begin
            // wrap once the index reaches the ring length
            idx_next = (idx_inc >= len_eff) ? '0 : idx_inc[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_frames_reg <= '0;
            held_left_reg    <= '0;
            held_right_reg   <= '0;
            idx_reg          <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                delay_frames_reg <= cfg_data;
            end
            if (accept)
            begin
                held_left_reg  <= held_left_next;
                held_right_reg <= held_right_next;
            end
            idx_reg <= idx_next;
        end
    end

endmodule

@@ rtl/sdcd_back.sv @@
// Back end: owns the delay ring memory, clears it after reset, reads the slot
// as a beat leaves the middle queue and mixes/writes back one stage later.
// Depends on sdcd_pkg.
module sdcd_back #(
    parameter int MAX_DELAY_FRAMES = sdcd_pkg::MAX_DELAY_FRAMES,
    parameter int IDX_W            = $clog2(MAX_DELAY_FRAMES)
) (
    input  logic                clk,
    input  logic                rst_n,
    output logic                clearing,
    input  logic                mid_empty,
    input  logic                mid_mix,
    input  logic [IDX_W-1:0]    mid_idx,
    input  sdcd_pkg::out_item_t mid_pair,
    output logic                mid_pop,
    input  logic                outq_full,
    output logic                outq_push,
    output sdcd_pkg::out_item_t outq_item
);
    import sdcd_pkg::*;

    localparam int SLOT_W = 2 * SAMPLE_W;
    localparam int MIX_W  = SAMPLE_W + 3;

    logic [SLOT_W-1:0]          ring_mem [MAX_DELAY_FRAMES];
    logic [SLOT_W-1:0]          rdata_reg;
    logic                       clr_busy_reg;
    logic [IDX_W-1:0]           clr_addr_reg;
    logic                       s2_valid_reg;
    logic                       s2_mix_reg;
    logic [IDX_W-1:0]           s2_idx_reg;
    out_item_t                  s2_pair_reg;
    logic                       s2_go;
    logic                       s2_ready;
    logic                       we;
    logic [IDX_W-1:0]           waddr;
    logic [SLOT_W-1:0]          wdata;
    logic signed [SAMPLE_W-1:0] dl;
    logic signed [SAMPLE_W-1:0] dr;
    logic [MIX_W-1:0]           lx, rx;
    logic [MIX_W-1:0]           lsum, rsum;
    out_item_t                  mixed;

    assign clearing = clr_busy_reg;
    assign s2_go    = s2_valid_reg && !outq_full;
    assign s2_ready = !s2_valid_reg || s2_go;
    assign mid_pop  = !mid_empty && s2_ready && !clr_busy_reg;

    // slot layout: left in the low half, right in the high half
    assign dl = rdata_reg[SAMPLE_W-1:0];
    assign dr = rdata_reg[SLOT_W-1:SAMPLE_W];

    always_comb
    begin
        lx   = {{3{s2_pair_reg.out_left[SAMPLE_W-1]}}, s2_pair_reg.out_left};
        rx   = {{3{s2_pair_reg.out_right[SAMPLE_W-1]}}, s2_pair_reg.out_right};
        lsum = (lx << 1) + lx + {{3{dr[SAMPLE_W-1]}}, dr};
        rsum = (rx << 1) + rx + {{3{dl[SAMPLE_W-1]}}, dl};
        mixed.out_left  = lsum[SAMPLE_W+1:2];
        mixed.out_right = rsum[SAMPLE_W+1:2];
        outq_push = s2_go;
        outq_item = s2_mix_reg ? mixed : s2_pair_reg;
        if (clr_busy_reg)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else
        begin
            we    = s2_go && s2_mix_reg;
            waddr = s2_idx_reg;
            wdata = {mixed.out_right, mixed.out_left};
        end
    end

    // consecutive mixed beats always use different slots, so the read of the
    // next beat never meets the write of the current one
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_mem[waddr] <= wdata;
        end
        if (mid_pop)
        begin
            rdata_reg <= ring_mem[mid_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            s2_mix_reg  <= mid_mix;
            s2_idx_reg  <= mid_idx;
            s2_pair_reg <= mid_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == IDX_W'(MAX_DELAY_FRAMES - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= mid_pop;
            end
        end
    end

endmodule

@@ rtl/stereo_decimate_cross_delay_core.sv @@
// Stereo 2:1 decimator with cross-feedback delay ring, top level.
// Depends on sdcd_pkg, sdcd_front, sdcd_fifo and sdcd_back.
//
// Takes one input beat (two oversampled stereo frames) per clock while full
// is low and returns one decimated, delay-mixed stereo frame per beat, in
// order. A beat moves from the input through a two-entry queue into the mix
// stage, where the ring slot read issued on the way in is mixed and written
// back, then into a two-entry result queue. Throughput is one beat per cycle
// when neither queue fills, set by the single read and single write port of
// the ring memory. After reset the ring is swept to zero one slot per cycle
// over all MAX_DELAY_FRAMES slots, with full held high; configuration writes
// are always taken (cfg_ready is tied high) and must only be issued while no
// beat is in flight.
module stereo_decimate_cross_delay_core #(
    parameter int MAX_DELAY_FRAMES = sdcd_pkg::MAX_DELAY_FRAMES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  sdcd_pkg::in_item_t               in_item,
    output logic                             empty,
    input  logic                             pop,
    output sdcd_pkg::out_item_t              out_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sdcd_pkg::DELAY_CFG_W-1:0] cfg_data
);
    import sdcd_pkg::*;

    localparam int IDX_W   = $clog2(MAX_DELAY_FRAMES);
    localparam int PAIR_W  = $bits(out_item_t);
    localparam int MID_W   = 1 + IDX_W + PAIR_W;

    logic             clearing;
    logic             mid_push;
    logic             mid_full;
    logic             mid_pop;
    logic             mid_empty;
    logic             f_mix;
    logic [IDX_W-1:0] f_idx;
    out_item_t        f_pair;
    logic [MID_W-1:0] mid_wdata;
    logic [MID_W-1:0] mid_rdata;
    logic             b_mix;
    logic [IDX_W-1:0] b_idx;
    out_item_t        b_pair;
    logic             outq_push;
    logic             outq_full;
    out_item_t        outq_item;

    assign cfg_ready = 1'b1;
    assign mid_wdata = {f_mix, f_idx, f_pair};
    assign {b_mix, b_idx, b_pair} = mid_rdata;

    sdcd_front #(
        .MAX_DELAY_FRAMES (MAX_DELAY_FRAMES),
        .IDX_W            (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .mid_full  (mid_full),
        .mid_push  (mid_push),
        .mid_mix   (f_mix),
        .mid_idx   (f_idx),
        .mid_pair  (f_pair)
    );

    sdcd_fifo #(
        .WIDTH (MID_W)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    sdcd_back #(
        .MAX_DELAY_FRAMES (MAX_DELAY_FRAMES),
        .IDX_W            (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .mid_empty (mid_empty),
        .mid_mix   (b_mix),
        .mid_idx   (b_idx),
        .mid_pair  (b_pair),
        .mid_pop   (mid_pop),
        .outq_full (outq_full),
        .outq_push (outq_push),
        .outq_item (outq_item)
    );

    sdcd_fifo #(
        .WIDTH (PAIR_W)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (outq_push),
        .wdata (outq_item),
        .full  (outq_full),
        .pop   (pop),
        .rdata (out_item),
        .empty (empty)
    );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for stereo_decimate_cross_delay_core: decimation and ring mixing.
// Depends on sdcd_pkg and the core RTL. Has its own predictor and a queue of expected frames.
module testbench;
    import sdcd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RX_HOLD_CYCLES = 64;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    in_item_t               in_item;
    logic                   empty;
    logic                   pop;
    out_item_t              out_item;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [DELAY_CFG_W-1:0] cfg_data;

    in_item_t  frame_pairs_q[$];
    out_item_t mixed_frames_q[$];

    // Predictor state
    logic [DELAY_CFG_W-1:0]     delay_len_cfg;
    logic signed [QUARTER_W-1:0] held_left_q;
    logic signed [QUARTER_W-1:0] held_right_q;
    logic [31:0]                 delay_ring [MAX_DELAY_FRAMES];
    logic [11:0]                 ring_pos;

    int send_idle_pct;
    int recv_idle_pct;
    bit rx_hold_request;
    bit rx_stalled;
    int error_count;
    int cycle_count;

    stereo_decimate_cross_delay_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic out_item_t decimate_and_mix(in_item_t f);
        int fl;
        int fr;
        int sl;
        int sr;
        int ql;
        int qr;
        int left;
        int right;
        int dl;
        int dr;
        int eff_len;
        int nxt;
        logic [31:0] slot;
        out_item_t res;
        fl = $signed(f.first_left);
        fr = $signed(f.first_right);
        sl = $signed(f.second_left);
        sr = $signed(f.second_right);
        ql = sl >>> 2;
        qr = sr >>> 2;
        left = int'(held_left_q) + (fl >>> 1) + ql;
        right = int'(held_right_q) + (fr >>> 1) + qr;
        held_left_q = ql[QUARTER_W-1:0];
        held_right_q = qr[QUARTER_W-1:0];
        eff_len = (delay_len_cfg > MAX_DELAY_FRAMES) ? MAX_DELAY_FRAMES : int'(delay_len_cfg);
        if (eff_len >= MIN_DELAY_FRAMES)
        begin
            slot = delay_ring[ring_pos];
            dl = $signed(slot[15:0]);
            dr = $signed(slot[31:16]);
            left = (left * 3 + dr) >>> 2;
            right = (right * 3 + dl) >>> 2;
            delay_ring[ring_pos] = {right[15:0], left[15:0]};
            // an index past a shortened length is used once, then wraps
            nxt = int'(ring_pos) + 1;
            if (nxt >= eff_len)
                nxt = 0;
            ring_pos = nxt[11:0];
        end
        res.out_left = left[15:0];
        res.out_right = right[15:0];
        return res;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_frames(input logic [15:0] fl, input logic [15:0] fr,
                                input logic [15:0] sl, input logic [15:0] sr);
        in_item_t f;
        f.first_left = fl;
        f.first_right = fr;
        f.second_left = sl;
        f.second_right = sr;
        frame_pairs_q.push_back(f);
    endtask

    task automatic queue_random(input int n);
        repeat (n)
            queue_frames(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    endtask

    task automatic wait_drained();
        while (frame_pairs_q.size() != 0 || mixed_frames_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_delay_len(input logic [DELAY_CFG_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        // ready only moves at the rising edge, so its value here holds for the next one
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        delay_len_cfg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sender
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (frame_pairs_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            push <= 1'b1;
            in_item <= frame_pairs_q[0];
        end
        else
            push <= 1'b0;
    end

    // Receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= !rx_stalled && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver hold-off while the sender keeps offering beats
    always
    begin
        @(posedge clk);
        if (rx_hold_request)
        begin
            rx_hold_request = 1'b0;
            rx_stalled = 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_stalled = 1'b0;
        end
    end

    // Accept beats on both sides and check results
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                mixed_frames_q.push_back(decimate_and_mix(in_item));
                void'(frame_pairs_q.pop_front());
            end
            if (pop && !empty)
            begin
                if (mixed_frames_q.size() == 0)
                begin
                    $display("%0t unexpected result beat: left %0d right %0d",
                             $time, out_item.out_left, out_item.out_right);
                    error_count++;
                end
                else
                begin
                    want = mixed_frames_q.pop_front();
                    if (out_item.out_left !== want.out_left)
                    begin
                        $display("%0t out_left mismatch: expected %0d actual %0d",
                                 $time, want.out_left, out_item.out_left);
                        error_count++;
                    end
                    if (out_item.out_right !== want.out_right)
                    begin
                        $display("%0t out_right mismatch: expected %0d actual %0d",
                                 $time, want.out_right, out_item.out_right);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 18;
        recv_idle_pct = 79;
        rx_hold_request = 1'b0;
        rx_stalled = 1'b0;
        error_count = 0;
        cycle_count = 0;
        delay_len_cfg = '0;
        held_left_q = '0;
        held_right_q = '0;
        ring_pos = '0;
        for (int i = 0; i < MAX_DELAY_FRAMES; i++)
            delay_ring[i] = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Bypass with extreme samples
        write_delay_len(13'd1);
        queue_frames(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_frames(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_frames(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_frames(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        queue_frames(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_frames(16'h0001, 16'h0001, 16'h0001, 16'h0001);
        queue_frames(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);

        // Shortest ring: feedback shows up after two beats
        write_delay_len(13'd2);
        queue_frames(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_frames(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_frames(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_frames(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_frames(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);

        // Length beyond the ring size clamps to the ring size
        write_delay_len(13'h1FFF);
        queue_frames(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        queue_frames(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        queue_frames(16'h1234, 16'hEDCB, 16'h5555, 16'hAAAA);
        queue_frames(16'h0000, 16'hFFFF, 16'h0001, 16'h8000);

        write_delay_len(13'd4096);
        queue_frames(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        queue_frames(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        queue_frames(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);

        write_delay_len(13'd13);
        queue_random(150);

        // Park the index at 20, past the next length, then shorten
        write_delay_len(13'd40);
        queue_random(60 - int'(ring_pos));
        write_delay_len(13'd3);
        queue_random(100);

        send_idle_pct = 79;
        recv_idle_pct = 18;
        write_delay_len(13'd0);
        queue_random(60);
        write_delay_len(13'd7);
        queue_random(150);

        write_delay_len(13'd4096);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_hold_request = 1'b1;
        queue_random(60);
        write_delay_len(13'd2);
        queue_random(120);

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ stereo_decimate_cross_delay_core.f @@
rtl/sdcd_pkg.sv
rtl/sdcd_fifo.sv
rtl/sdcd_front.sv
rtl/sdcd_back.sv
rtl/stereo_decimate_cross_delay_core.sv
verif/testbench.sv
